/* rtl/core/tct_pkg.sv */
// ----------------------------------------------------------------------------
// tct_pkg
// Shared constants, codes and types of the toroidal column table.
// ----------------------------------------------------------------------------
package tct_pkg;

  localparam int SECTIONS   = 8;
  localparam int MAX_RADIUS = 15;
  localparam int CELLS      = 1024;
  localparam int CELL_W     = $clog2(CELLS);
  localparam int SEC_W      = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int EDGE_W     = $clog2(2 * MAX_RADIUS + 2);
  localparam int AXIS_W     = EDGE_W + 1;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam logic [15:0] NO_MESH_CODE = 16'hFFFF;

  // operation codes
  localparam logic [2:0] OP_CLAIM     = 3'd0;
  localparam logic [2:0] OP_SET_VIS   = 3'd1;
  localparam logic [2:0] OP_CLEAR     = 3'd2;
  localparam logic [2:0] OP_QUERY     = 3'd3;
  localparam logic [2:0] OP_SET_MESH  = 3'd4;
  localparam logic [2:0] OP_SET_DIRTY = 3'd5;
  localparam logic [2:0] OP_OCCUPANT  = 3'd6;

  // register indexes
  localparam logic [1:0] CFG_RADIUS   = 2'd0;
  localparam logic [1:0] CFG_CENTRE_X = 2'd1;
  localparam logic [1:0] CFG_CENTRE_Z = 2'd2;

  // classified item, as queued between front and back
  typedef struct packed {
    logic [2:0]        op;
    logic [3:0]        sec;
    logic [15:0]       vis;
    logic [15:0]       mesh;
    logic              dirty;
    logic              inr;
    logic [AXIS_W-1:0] dx;
    logic [AXIS_W-1:0] dz;
    logic [31:0]       cx;
    logic [31:0]       cz;
  } item_t;

  // grid geometry and clear request from front to back
  typedef struct packed {
    logic [EDGE_W-1:0] edge_len;
    logic [EDGE_W-1:0] base_x;
    logic [EDGE_W-1:0] base_z;
    logic              clear_req;
  } geo_t;

  // one cell of the store
  typedef struct packed {
    logic                      valid;
    logic [SECTIONS-1:0]       dirty;
    logic [SECTIONS-1:0][15:0] vis;
    logic [SECTIONS-1:0][15:0] mesh;
    logic [31:0]               tag_x;
    logic [31:0]               tag_z;
  } row_t;

  typedef enum logic [1:0] {MOD_IDLE, MOD_RUN, MOD_FIX} mod_state_t;
  typedef enum logic [1:0] {BK_CLEAR, BK_IDLE, BK_EXEC} bk_state_t;

endpackage

/* rtl/core/tct_front.sv */
// ----------------------------------------------------------------------------
// tct_front
// Configuration registers, base remainder unit and item classification.
// ----------------------------------------------------------------------------
module tct_front import tct_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_addr,
  input  logic [31:0]  cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [2:0]   in_tuser,
  input  logic [103:0] in_tdata,
  input  logic         q_full,
  input  logic         clr_busy,
  output logic         push,
  output item_t        push_item,
  output geo_t         geo
);

  logic [3:0]        radius_r, radius_nxt;
  logic [31:0]       centre_x_r, centre_x_nxt, centre_z_r, centre_z_nxt;
  logic [EDGE_W-1:0] base_x_r, base_z_r, edge_len;
  logic [EDGE_W-1:0] rem_x_r, rem_z_r, rem_x_nxt, rem_z_nxt;
  logic [31:0]       mag_x_r, mag_z_r;
  logic              neg_x_r, neg_z_r;
  logic [4:0]        mod_cnt_r;
  mod_state_t        mod_state_r, mod_state_nxt;
  logic              cfg_wr, cfg_hit, mod_busy, step_en, fix_en;
  logic [EDGE_W:0]   tx, tz;
  logic [3:0]        r_clamp;
  logic signed [32:0] dx, dz, r_s;

  assign cfg_wr  = cfg_valid & cfg_ready;
  assign cfg_hit = cfg_wr & ((cfg_addr == CFG_RADIUS) || (cfg_addr == CFG_CENTRE_X) ||
                             (cfg_addr == CFG_CENTRE_Z));
  assign r_clamp = (cfg_data[3:0] > 4'(MAX_RADIUS)) ? 4'(MAX_RADIUS) : cfg_data[3:0];
  assign edge_len = EDGE_W'({radius_r, 1'b1});

  // next register values
  always_comb begin
    radius_nxt   = radius_r;
    centre_x_nxt = centre_x_r;
    centre_z_nxt = centre_z_r;
    if (cfg_wr && cfg_addr == CFG_RADIUS) radius_nxt = r_clamp;
    if (cfg_wr && cfg_addr == CFG_CENTRE_X) centre_x_nxt = cfg_data;
    if (cfg_wr && cfg_addr == CFG_CENTRE_Z) centre_z_nxt = cfg_data;
  end

  // remainder fsm next state
  always_comb begin
    mod_state_nxt = mod_state_r;
    case (mod_state_r)
      MOD_IDLE: if (cfg_hit) mod_state_nxt = MOD_RUN;
      MOD_RUN:  if (mod_cnt_r == 5'd31) mod_state_nxt = MOD_FIX;
      MOD_FIX:  mod_state_nxt = MOD_IDLE;
      default:  mod_state_nxt = MOD_IDLE;
    endcase
  end

  // remainder fsm outputs
  always_comb begin
    mod_busy = 1'b1;
    step_en  = 1'b0;
    fix_en   = 1'b0;
    case (mod_state_r)
      MOD_IDLE: mod_busy = 1'b0;
      MOD_RUN:  step_en  = 1'b1;
      MOD_FIX:  fix_en   = 1'b1;
      default:  mod_busy = 1'b1;
    endcase
  end

  // one restoring step per axis
  always_comb begin
    tx = {rem_x_r, mag_x_r[31]};
    tz = {rem_z_r, mag_z_r[31]};
    if (tx >= {1'b0, edge_len}) tx = tx - {1'b0, edge_len};
    if (tz >= {1'b0, edge_len}) tz = tz - {1'b0, edge_len};
    rem_x_nxt = tx[EDGE_W-1:0];
    rem_z_nxt = tz[EDGE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r    <= 4'd0;
      centre_x_r  <= 32'd0;
      centre_z_r  <= 32'd0;
      base_x_r    <= '0;
      base_z_r    <= '0;
      mod_state_r <= MOD_IDLE;
      mod_cnt_r   <= 5'd0;
    end else begin
      radius_r    <= radius_nxt;
      centre_x_r  <= centre_x_nxt;
      centre_z_r  <= centre_z_nxt;
      mod_state_r <= mod_state_nxt;
      if (cfg_hit) mod_cnt_r <= 5'd0;
      else if (step_en) mod_cnt_r <= mod_cnt_r + 5'd1;
      if (fix_en) begin
        base_x_r <= (neg_x_r && rem_x_r != '0) ? edge_len - rem_x_r : rem_x_r;
        base_z_r <= (neg_z_r && rem_z_r != '0) ? edge_len - rem_z_r : rem_z_r;
      end
    end
  end

  // remainder datapath
  always_ff @(posedge clk) begin
    if (cfg_hit) begin
      neg_x_r <= centre_x_nxt[31];
      neg_z_r <= centre_z_nxt[31];
      mag_x_r <= centre_x_nxt[31] ? (~centre_x_nxt + 32'd1) : centre_x_nxt;
      mag_z_r <= centre_z_nxt[31] ? (~centre_z_nxt + 32'd1) : centre_z_nxt;
      rem_x_r <= '0;
      rem_z_r <= '0;
    end else if (step_en) begin
      mag_x_r <= {mag_x_r[30:0], 1'b0};
      mag_z_r <= {mag_z_r[30:0], 1'b0};
      rem_x_r <= rem_x_nxt;
      rem_z_r <= rem_z_nxt;
    end
  end

  // offsets from centre and range check
  assign r_s = $signed({29'd0, radius_r});
  assign dx  = $signed({in_tdata[31], in_tdata[31:0]}) - $signed({centre_x_r[31], centre_x_r});
  assign dz  = $signed({in_tdata[63], in_tdata[63:32]}) - $signed({centre_z_r[31], centre_z_r});

  always_comb begin
    push_item.op    = in_tuser;
    push_item.cx    = in_tdata[31:0];
    push_item.cz    = in_tdata[63:32];
    push_item.sec   = in_tdata[67:64];
    push_item.vis   = in_tdata[83:68];
    push_item.mesh  = in_tdata[99:84];
    push_item.dirty = in_tdata[100];
    push_item.inr   = (dx >= -r_s) && (dx <= r_s) && (dz >= -r_s) && (dz <= r_s);
    push_item.dx    = dx[AXIS_W-1:0];
    push_item.dz    = dz[AXIS_W-1:0];
  end

  assign cfg_ready = ~mod_busy;
  assign in_tready = ~mod_busy & ~clr_busy & ~q_full;
  assign push      = in_tvalid & in_tready;

  assign geo.edge_len  = edge_len;
  assign geo.base_x    = base_x_r;
  assign geo.base_z    = base_z_r;
  assign geo.clear_req = cfg_wr & (cfg_addr == CFG_RADIUS);

endmodule

/* rtl/core/tct_queue.sv */
// ----------------------------------------------------------------------------
// tct_queue
// Short queue of classified words between front and back.
// ----------------------------------------------------------------------------
module tct_queue import tct_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head,
  output logic  full,
  output logic  empty
);

  item_t             ent_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;

  assign full  = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = ent_r[rd_ptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= push_item;
  end

endmodule

/* rtl/core/tct_back.sv */
// ----------------------------------------------------------------------------
// tct_back
// Cell store with clearing pass, read-modify-write of one cell per word.
// ----------------------------------------------------------------------------
module tct_back import tct_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  geo_t         geo,
  input  item_t        head,
  input  logic         q_empty,
  output logic         pop,
  output logic         clr_busy,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata
);

  row_t              mem [CELLS];
  row_t              rd_row_r, new_row, rst_row;
  item_t             cur_r;
  logic [CELL_W-1:0] cur_cell_r, head_cell, clr_cnt_r, wa;
  bk_state_t         state_r, state_nxt;
  logic              out_valid_r, we, fnd, nfnd, sec_ok;
  logic [103:0]      out_data_r, res;
  logic [EDGE_W-1:0] wx, wz;
  logic [2*EDGE_W-1:0] prod;
  logic [SEC_W-1:0]  si;

  function automatic logic [EDGE_W-1:0] wrap_axis(input logic [EDGE_W-1:0] b,
                                                  input logic [AXIS_W-1:0] d,
                                                  input logic [EDGE_W-1:0] e);
    logic signed [AXIS_W:0] v;
    logic signed [AXIS_W:0] es;
    es = $signed({2'b00, e});
    v  = $signed({2'b00, b}) + $signed({d[AXIS_W-1], d});
    if (v < 0) v = v + es;
    else if (v >= es) v = v - es;
    return v[EDGE_W-1:0];
  endfunction

  // reset contents of a cell
  always_comb begin
    rst_row       = '0;
    rst_row.mesh  = {SECTIONS{NO_MESH_CODE}};
  end

  // cell index of the queue head
  assign wx        = wrap_axis(geo.base_x, head.dx, geo.edge_len);
  assign wz        = wrap_axis(geo.base_z, head.dz, geo.edge_len);
  assign prod      = wz * geo.edge_len;
  assign head_cell = CELL_W'(prod) + CELL_W'(wx);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_CLEAR: if (clr_cnt_r == CELL_W'(CELLS - 1)) state_nxt = BK_IDLE;
      BK_IDLE:  if (pop) state_nxt = BK_EXEC;
      BK_EXEC:  state_nxt = BK_IDLE;
      default:  state_nxt = BK_CLEAR;
    endcase
    if (geo.clear_req) state_nxt = BK_CLEAR;
  end

  // state outputs
  always_comb begin
    pop      = 1'b0;
    clr_busy = 1'b0;
    we       = 1'b0;
    wa       = cur_cell_r;
    case (state_r)
      BK_CLEAR: begin
        clr_busy = 1'b1;
        we       = 1'b1;
        wa       = clr_cnt_r;
      end
      BK_IDLE:  pop = ~q_empty & (~out_valid_r | out_tready);
      BK_EXEC:  we  = cur_r.inr;
      default:  clr_busy = 1'b1;
    endcase
  end

  // cell update and result
  always_comb begin
    sec_ok  = cur_r.sec < 4'(SECTIONS);
    si      = cur_r.sec[SEC_W-1:0];
    fnd     = rd_row_r.valid && rd_row_r.tag_x == cur_r.cx && rd_row_r.tag_z == cur_r.cz;
    nfnd    = fnd;
    new_row = rd_row_r;
    case (cur_r.op)
      OP_CLAIM: if (!fnd) begin
        new_row       = rst_row;
        new_row.tag_x = cur_r.cx;
        new_row.tag_z = cur_r.cz;
        new_row.valid = 1'b1;
        nfnd          = 1'b1;
      end
      OP_SET_VIS:   if (fnd && sec_ok) new_row.vis[si] = cur_r.vis;
      OP_CLEAR: if (fnd) begin
        new_row = rst_row;
        nfnd    = 1'b0;
      end
      OP_SET_MESH:  if (fnd && sec_ok) new_row.mesh[si] = cur_r.mesh;
      OP_SET_DIRTY: if (fnd && sec_ok) new_row.dirty[si] = cur_r.dirty;
      OP_QUERY, OP_OCCUPANT: new_row = rd_row_r;
      default: new_row = rd_row_r;
    endcase
    res        = '0;
    res[33:18] = NO_MESH_CODE;
    if (cur_r.inr) begin
      res[0] = 1'b1;
      res[1] = nfnd;
      if (nfnd && sec_ok) begin
        res[17:2]  = new_row.vis[si];
        res[33:18] = new_row.mesh[si];
        res[34]    = new_row.dirty[si];
      end
      if (new_row.valid) begin
        res[35]     = 1'b1;
        res[67:36]  = new_row.tag_x;
        res[99:68]  = new_row.tag_z;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (geo.clear_req) clr_cnt_r <= '0;
      else if (state_r == BK_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (state_r == BK_EXEC) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r      <= head;
      cur_cell_r <= head_cell;
    end
    if (state_r == BK_EXEC) out_data_r <= res;
  end

  // cell store
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= (state_r == BK_CLEAR) ? rst_row : new_row;
    if (pop) rd_row_r <= mem[head_cell];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == BK_EXEC))
    else $error("result raised without a cell update");
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_CLEAR) |-> !pop)
    else $error("word taken during clearing pass");
  a_exec_single: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_EXEC && !geo.clear_req) |=> (state_r == BK_IDLE))
    else $error("update did not return to idle");
  a_exec_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_EXEC) |-> !out_valid_r)
    else $error("result overwritten before taken");
`endif

endmodule

/* rtl/core/toroidal_column_table.sv */
// ----------------------------------------------------------------------------
// toroidal_column_table
// Toroidally indexed grid of column cells with per-section state.
// ----------------------------------------------------------------------------
// an accepted word is queued, then popped into the back with a read of its cell;
//   the result word is registered after the cell update; no new word is popped
//   until that update is done and the result register is free or being taken
// reset: synchronous rst_n; a clearing pass of the store follows reset and every
//   radius write, during which no input word is taken; a radius or centre write
//   runs the base remainder unit, with configuration and input held off meanwhile
// ----------------------------------------------------------------------------
module toroidal_column_table import tct_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_addr,
  input  logic [31:0]  cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [2:0]   in_tuser,   // op
  input  logic [103:0] in_tdata,   // chunk_x, chunk_z, section_y, vis_mask_in,
                                   // mesh_slot_in, dirty_in, zero fill
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata   // in_range, found, vis_mask, mesh_slot, dirty,
                                   // occupied, occupant_x, occupant_z, zero fill
);

  item_t push_item, head;
  geo_t  geo;
  logic  push, pop, q_full, q_empty, clr_busy;

  // front: configuration and classification
  tct_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .clr_busy  (clr_busy),
    .push      (push),
    .push_item (push_item),
    .geo       (geo)
  );

  // queue between the two sides
  tct_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // back: cell store and result
  tct_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .geo        (geo),
    .head       (head),
    .q_empty    (q_empty),
    .pop        (pop),
    .clr_busy   (clr_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
